// ===== src/hrd_pkg.sv =====
// ============================================================================
// hrd_pkg
// Shared types, constants and pattern tables for the HTTP response deframer.
// ============================================================================
package hrd_pkg;

    localparam int COUNT_BITS_DEF      = 32;
    localparam int LINE_COUNT_BITS_DEF = 16;

    localparam int NUM_PAT      = 6;
    localparam int PAT_BITS     = 136;   // longest pattern, 17 characters
    localparam int TAIL_LEN     = 14;
    localparam int TAIL_BITS    = 8 * TAIL_LEN;
    localparam int NUMBER_START = 16;    // first character after "Content-Length: "

    // Pattern slots
    localparam int PAT_OK_10 = 0;
    localparam int PAT_OK_11 = 1;
    localparam int PAT_V10   = 2;
    localparam int PAT_V11   = 3;
    localparam int PAT_CLEN  = 4;
    localparam int PAT_CONN  = 5;

    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;
    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_Z   = 8'h5A;

    localparam logic [TAIL_BITS-1:0] TAIL_OK_10 = "TTP/1.0 200 OK";
    localparam logic [TAIL_BITS-1:0] TAIL_OK_11 = "TTP/1.1 200 OK";

    typedef enum logic [1:0] {
        PH_STATUS  = 2'd0,
        PH_HEADERS = 2'd1,
        PH_BODY    = 2'd2
    } phase_t;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic       reply_done;
        logic       disconnect;
        logic       bad_status;
        logic       close_expected;
        logic [1:0] phase;
    } result_t;

    // Pattern text, left aligned, zero padded to 17 characters
    function automatic logic [PAT_BITS-1:0] pat_text(input int p);
        logic [PAT_BITS-1:0] s;
        case (p)
            PAT_OK_10: s = {"HTTP/1.0 200", 40'h0};
            PAT_OK_11: s = {"HTTP/1.1 200", 40'h0};
            PAT_V10:   s = {"HTTP/1.0 ", 64'h0};
            PAT_V11:   s = {"HTTP/1.1 ", 64'h0};
            PAT_CLEN:  s = {"Content-Length: ", 8'h0};
            PAT_CONN:  s = "Connection: Close";
            default:   s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] pat_len(input int p);
        logic [4:0] n;
        case (p)
            PAT_OK_10: n = 5'd12;
            PAT_OK_11: n = 5'd12;
            PAT_V10:   n = 5'd9;
            PAT_V11:   n = 5'd9;
            PAT_CLEN:  n = 5'd16;
            PAT_CONN:  n = 5'd17;
            default:   n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic pat_fold(input int p);
        return (p == PAT_CLEN) || (p == PAT_CONN);
    endfunction

    // Character i of pattern p
    function automatic logic [7:0] pat_char(input int p, input logic [4:0] i);
        logic [PAT_BITS-1:0] s;
        logic [4:0]          k;
        logic [7:0]          c;
        s = pat_text(p);
        k = 5'd16 - i;
        if (i > 5'd16)
            c = 8'h00;
        else
            c = s[k*8 +: 8];
        return c;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        if (c >= CHAR_A && c <= CHAR_Z)
            r = c + 8'd32;
        else
            r = c;
        return r;
    endfunction

endpackage

// ===== src/hrd_engine.sv =====
// ============================================================================
// hrd_engine
// Parser state and the single-pass byte step: line matching, length parse,
// body count.
// ============================================================================
module hrd_engine #(
    parameter int COUNT_BITS      = hrd_pkg::COUNT_BITS_DEF,
    parameter int LINE_COUNT_BITS = hrd_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [7:0]       data_byte,
    input  logic             downstream_idle,
    output hrd_pkg::result_t result
);

    localparam int NP = hrd_pkg::NUM_PAT;
    localparam int TB = hrd_pkg::TAIL_BITS;

    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_t;

    hrd_pkg::phase_t            phase_reg, phase_next;
    logic [LINE_COUNT_BITS-1:0] line_len_reg, line_len_next;
    logic [NP-1:0]              flags_reg, flags_next;
    logic [TB-1:0]              tail_reg, tail_next;
    logic [COUNT_BITS-1:0]      acc_reg, acc_next;
    num_phase_t                 nph_reg, nph_next;
    logic [COUNT_BITS-1:0]      clen_reg, clen_next;
    logic [COUNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                       creq_reg, creq_next;
    logic                       cok_reg, cok_next;
    logic                       err_reg, err_next;

    // State as seen by the character handler (after a body end flush)
    hrd_pkg::phase_t            b_phase;
    logic [LINE_COUNT_BITS-1:0] b_len;
    logic [NP-1:0]              b_flags;
    logic [TB-1:0]              b_tail;
    logic [COUNT_BITS-1:0]      b_acc;
    num_phase_t                 b_nph;

    logic                       in_body;
    logic                       consumed;
    logic                       done;
    logic                       bad;
    logic [COUNT_BITS-1:0]      cnt_after;
    logic [NP-1:0]              hit;
    logic [NP-1:0]              miss;
    logic                       tail_hit;
    logic                       is_digit;
    logic                       is_space;
    logic [COUNT_BITS+3:0]      prod;
    logic [COUNT_BITS-1:0]      acc_step;
    logic [7:0]                 want;
    logic [7:0]                 got;

    always_comb
    begin
        in_body   = (phase_reg == hrd_pkg::PH_BODY);
        consumed  = in_body && (cnt_reg < clen_reg);
        cnt_after = consumed ? cnt_reg + 1'b1 : cnt_reg;
        done      = in_body && (downstream_idle || (cnt_after >= clen_reg));
        bad       = 1'b0;

        // base state: flushed when the body ends, close_ok kept
        if (done)
        begin
            b_phase   = hrd_pkg::PH_STATUS;
            b_len     = '0;
            b_flags   = '1;
            b_tail    = '0;
            b_acc     = '0;
            b_nph     = NUM_SKIP;
            clen_next = '0;
            cnt_next  = '0;
            creq_next = 1'b0;
            err_next  = 1'b0;
        end
        else
        begin
            b_phase   = phase_reg;
            b_len     = line_len_reg;
            b_flags   = flags_reg;
            b_tail    = tail_reg;
            b_acc     = acc_reg;
            b_nph     = nph_reg;
            clen_next = clen_reg;
            cnt_next  = cnt_after;
            creq_next = creq_reg;
            err_next  = err_reg;
        end
        cok_next      = cok_reg;
        phase_next    = b_phase;
        line_len_next = b_len;
        flags_next    = b_flags;
        tail_next     = b_tail;
        acc_next      = b_acc;
        nph_next      = b_nph;

        // pattern compare for every slot at the current position
        for (int p = 0; p < NP; p++)
        begin
            want = hrd_pkg::pat_char(p, b_len[4:0]);
            got  = data_byte;
            if (hrd_pkg::pat_fold(p))
            begin
                want = hrd_pkg::fold(want);
                got  = hrd_pkg::fold(got);
            end
            miss[p] = (b_len < LINE_COUNT_BITS'(hrd_pkg::pat_len(p))) && (got != want);
            hit[p]  = b_flags[p] && (b_len >= LINE_COUNT_BITS'(hrd_pkg::pat_len(p)));
        end
        tail_hit = (b_len >= LINE_COUNT_BITS'(hrd_pkg::TAIL_LEN)) &&
                   ((b_tail == hrd_pkg::TAIL_OK_10) || (b_tail == hrd_pkg::TAIL_OK_11));

        // decimal accumulate with saturation
        is_digit = data_byte inside {[hrd_pkg::CHAR_0:hrd_pkg::CHAR_9]};
        is_space = data_byte inside {hrd_pkg::CHAR_SP, hrd_pkg::CHAR_TAB,
                                     hrd_pkg::CHAR_VT, hrd_pkg::CHAR_FF};
        prod     = ({4'b0, b_acc} << 3) + ({4'b0, b_acc} << 1)
                 + (COUNT_BITS+4)'(data_byte[3:0]);
        acc_step = (|prod[COUNT_BITS+3:COUNT_BITS]) ? '1 : prod[COUNT_BITS-1:0];

        if (!consumed)
        begin
            if (data_byte == hrd_pkg::CHAR_LF)
            begin
                line_len_next = '0;
                flags_next    = '1;
                tail_next     = '0;
                acc_next      = '0;
                nph_next      = NUM_SKIP;
                if (b_phase == hrd_pkg::PH_HEADERS)
                begin
                    if (b_len == '0)
                    begin
                        phase_next = hrd_pkg::PH_BODY;
                        cok_next   = 1'b1;
                    end
                    else if (hit[hrd_pkg::PAT_CLEN])
                        clen_next = b_acc;
                    else if (hit[hrd_pkg::PAT_CONN])
                        creq_next = 1'b1;
                end
                else
                begin
                    creq_next = 1'b0;
                    cok_next  = 1'b0;
                    if (hit[hrd_pkg::PAT_OK_10] || hit[hrd_pkg::PAT_OK_11] || tail_hit)
                        phase_next = hrd_pkg::PH_HEADERS;
                    else if (hit[hrd_pkg::PAT_V10] || hit[hrd_pkg::PAT_V11])
                    begin
                        err_next   = 1'b1;
                        phase_next = hrd_pkg::PH_HEADERS;
                    end
                    else
                    begin
                        phase_next = hrd_pkg::PH_STATUS;
                        clen_next  = '0;
                        cnt_next   = '0;
                        err_next   = 1'b0;
                        bad        = 1'b1;
                    end
                end
            end
            else if (data_byte != hrd_pkg::CHAR_CR)
            begin
                flags_next = b_flags & ~miss;
                if (b_phase == hrd_pkg::PH_HEADERS &&
                    b_len >= LINE_COUNT_BITS'(hrd_pkg::NUMBER_START))
                begin
                    case (b_nph)
                        NUM_SKIP:
                        begin
                            if (is_digit)
                            begin
                                acc_next = COUNT_BITS'(data_byte[3:0]);
                                nph_next = NUM_DIGITS;
                            end
                            else if (!is_space)
                                nph_next = NUM_DONE;
                        end
                        NUM_DIGITS:
                        begin
                            if (is_digit)
                                acc_next = acc_step;
                            else
                                nph_next = NUM_DONE;
                        end
                        default:
                            nph_next = b_nph;
                    endcase
                end
                tail_next = {b_tail[TB-9:0], data_byte};
                if (b_len != '1)
                    line_len_next = b_len + 1'b1;
            end
        end

        result.body_valid     = consumed && !err_reg;
        result.body_byte      = (consumed && !err_reg) ? data_byte : 8'h00;
        result.reply_done     = done;
        result.disconnect     = done && creq_reg;
        result.bad_status     = bad;
        result.close_expected = cok_next;
        result.phase          = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= hrd_pkg::PH_STATUS;
            line_len_reg <= '0;
            flags_reg    <= '1;
            tail_reg     <= '0;
            acc_reg      <= '0;
            nph_reg      <= NUM_SKIP;
            clen_reg     <= '0;
            cnt_reg      <= '0;
            creq_reg     <= 1'b0;
            cok_reg      <= 1'b0;
            err_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            line_len_reg <= line_len_next;
            flags_reg    <= flags_next;
            tail_reg     <= tail_next;
            acc_reg      <= acc_next;
            nph_reg      <= nph_next;
            clen_reg     <= clen_next;
            cnt_reg      <= cnt_next;
            creq_reg     <= creq_next;
            cok_reg      <= cok_next;
            err_reg      <= err_next;
        end
    end

endmodule

// ===== src/hrd_out_buf.sv =====
// ============================================================================
// hrd_out_buf
// Two-entry result buffer; decouples the result channel from the input side.
// ============================================================================
module hrd_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hrd_pkg::result_t push_data,
    input  logic             pop,
    output logic             head_valid,
    output hrd_pkg::result_t head_data,
    output logic             full
);

    hrd_pkg::result_t mem [2];
    logic [1:0]       count_reg, count_next;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;

    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

endmodule

// ===== src/http_response_deframer_core.sv =====
// ============================================================================
// http_response_deframer_core
// Frames an HTTP/1.x response one byte per transfer and forwards body bytes.
// ============================================================================
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+----------------------------------
//  item     | item_valid / item_ready     | data_byte, downstream_idle
//  result   | result_valid / result_ready | body_valid, body_byte, reply_done,
//           |                             | disconnect, bad_status,
//           |                             | close_expected, phase
//
//  One item per cycle sustained while the result side keeps up; each item yields exactly one result.
//  Path: the byte waits in the input register, then the parse step writes
//  the two-entry result buffer, whose head drives result_valid and the
//  result payload.
//  Reset is asynchronous and brings the parser to the status line state
//  with no clearing pass; item_ready is high during reset and from its
//  release on.
//  A stalled result side fills the result buffer; item_ready drops only
//  when both entries are held and the input register is occupied.
//
module http_response_deframer_core #(
    parameter int COUNT_BITS      = hrd_pkg::COUNT_BITS_DEF,
    parameter int LINE_COUNT_BITS = hrd_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic       downstream_idle,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       body_valid,
    output logic [7:0] body_byte,
    output logic       reply_done,
    output logic       disconnect,
    output logic       bad_status,
    output logic       close_expected,
    output logic [1:0] phase
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_idle_reg;
    logic             advance;
    logic             buf_full;
    hrd_pkg::result_t step_result;
    hrd_pkg::result_t head;

    // Advance the held byte through the parse step when the buffer has room
    assign advance    = in_valid_reg && !buf_full;
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ready)
            in_valid_reg <= item_valid;
    end

    // Payload capture; hold while the input register is stalled
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_byte_reg <= data_byte;
            in_idle_reg <= downstream_idle;
        end
    end

    hrd_engine #(
        .COUNT_BITS      (COUNT_BITS),
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (advance),
        .data_byte       (in_byte_reg),
        .downstream_idle (in_idle_reg),
        .result          (step_result)
    );

    hrd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (advance),
        .push_data  (step_result),
        .pop        (result_valid && result_ready),
        .head_valid (result_valid),
        .head_data  (head),
        .full       (buf_full)
    );

    assign body_valid     = head.body_valid;
    assign body_byte      = head.body_byte;
    assign reply_done     = head.reply_done;
    assign disconnect     = head.disconnect;
    assign bad_status     = head.bad_status;
    assign close_expected = head.close_expected;
    assign phase          = head.phase;

endmodule

// ===== src/hrd_checker.sv =====
// ============================================================================
// hrd_checker
// Port-level checks on the deframer's result stream.
// ============================================================================
module hrd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_ready,
    input logic       body_valid,
    input logic [7:0] body_byte,
    input logic       reply_done,
    input logic       disconnect,
    input logic       bad_status,
    input logic       close_expected,
    input logic [1:0] phase
);

    // Forwarded byte is zero unless flagged as a body byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !body_valid) |-> (body_byte == 8'h00))
        else $error("body_byte nonzero without body_valid");

    // Disconnect comes only with the end of a reply
    a_disc_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && disconnect) |-> reply_done)
        else $error("disconnect without reply_done");

    // A bad status leaves the parser in the status line with close cleared
    a_bad_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && bad_status) |->
            (phase == hrd_pkg::PH_STATUS && !close_expected && !body_valid))
        else $error("bad_status did not reset parser");

    // A body byte is only forwarded once the headers have closed
    a_body_close: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && body_valid) |-> close_expected)
        else $error("body byte forwarded before end of headers");

    // Stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(body_byte) && $stable(phase)
             && $stable(reply_done)))
        else $error("stalled result changed");

endmodule

bind http_response_deframer_core hrd_checker u_hrd_checker (.*);

// ===== tb/http_response_deframer_core_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// http_response_deframer_core_test
// Self-checking bench for the HTTP response deframer. It feeds response byte
// streams, predicts the per-byte result with its own parser model and checks
// every result transfer field by field against the oldest prediction.
// ============================================================================
module http_response_deframer_core_test;

    // Parser state of the length-number scanner after "Content-Length: "
    typedef enum logic [1:0] {
        DIG_SKIP = 2'd0,
        DIG_READ = 2'd1,
        DIG_DONE = 2'd2
    } digit_state_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       item_valid      = 1'b0;
    logic       item_ready;
    logic [7:0] data_byte       = 8'h00;
    logic       downstream_idle = 1'b0;
    logic       result_valid;
    logic       result_ready    = 1'b0;
    logic       body_valid;
    logic [7:0] body_byte;
    logic       reply_done;
    logic       disconnect;
    logic       bad_status;
    logic       close_expected;
    logic [1:0] phase;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    http_response_deframer_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .data_byte      (data_byte),
        .downstream_idle(downstream_idle),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .body_valid     (body_valid),
        .body_byte      (body_byte),
        .reply_done     (reply_done),
        .disconnect     (disconnect),
        .bad_status     (bad_status),
        .close_expected (close_expected),
        .phase          (phase)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    hrd_pkg::result_t due_results[$];      // predicted results, oldest first
    int unsigned mismatches      = 0;
    int unsigned bytes_sent      = 0;
    bit          no_idle_stretch = 1'b0; // while set, neither side idles
    int unsigned stall_left      = 0;

    // ------------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------------
    hrd_pkg::phase_t    rx_phase;
    logic [15:0]        line_len;     // saturating character count of the line
    logic [7:0]         pfx_ok;       // one flag per prefix pattern
    logic [hrd_pkg::TAIL_BITS-1:0] tail_chars; // last 14 characters, newest low
    logic [31:0]        len_acc;
    digit_state_t       num_state;
    logic [31:0]        body_len;
    logic [31:0]        body_cnt;
    logic               want_close;
    logic               close_flag;
    logic               err_reply;

    function automatic string pat_str(input int p);
        case (p)
            hrd_pkg::PAT_OK_10: return "HTTP/1.0 200";
            hrd_pkg::PAT_OK_11: return "HTTP/1.1 200";
            hrd_pkg::PAT_V10:   return "HTTP/1.0 ";
            hrd_pkg::PAT_V11:   return "HTTP/1.1 ";
            hrd_pkg::PAT_CLEN:  return "Content-Length: ";
            hrd_pkg::PAT_CONN:  return "Connection: Close";
            default:            return "";
        endcase
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= hrd_pkg::CHAR_A && c <= hrd_pkg::CHAR_Z) ? c + 8'd32 : c;
    endfunction

    function automatic void restart_line();
        line_len   = '0;
        pfx_ok     = '1;
        tail_chars = '0;
        len_acc    = '0;
        num_state  = DIG_SKIP;
    endfunction

    function automatic void restart_reply();
        rx_phase = hrd_pkg::PH_STATUS;
        restart_line();
        body_len   = '0;
        body_cnt   = '0;
        want_close = 1'b0;
        close_flag = 1'b0;
        err_reply  = 1'b0;
    endfunction

    function automatic logic prefix_hit(input int p);
        string s;
        s = pat_str(p);
        return pfx_ok[p] && (line_len >= s.len());
    endfunction

    // Fold one line character into the pattern flags, the length scanner and
    // the tail window
    function automatic void add_char(input logic [7:0] c);
        string       s;
        logic [7:0]  w;
        logic [7:0]  g;
        logic [31:0] d;
        logic        digit;
        for (int p = 0; p < hrd_pkg::NUM_PAT; p++)
        begin
            s = pat_str(p);
            if (line_len < s.len())
            begin
                w = s[line_len];
                g = c;
                if (p == hrd_pkg::PAT_CLEN || p == hrd_pkg::PAT_CONN)
                begin
                    w = to_lower(w);
                    g = to_lower(g);
                end
                if (g != w)
                    pfx_ok[p] = 1'b0;
            end
        end
        if (rx_phase == hrd_pkg::PH_HEADERS && line_len >= hrd_pkg::NUMBER_START)
        begin
            digit = (c >= hrd_pkg::CHAR_0 && c <= hrd_pkg::CHAR_9);
            d     = {24'h0, c - hrd_pkg::CHAR_0};
            case (num_state)
                DIG_SKIP:
                begin
                    if (digit)
                    begin
                        len_acc   = d;
                        num_state = DIG_READ;
                    end
                    else if (!(c == hrd_pkg::CHAR_SP || c == hrd_pkg::CHAR_TAB ||
                               c == hrd_pkg::CHAR_VT || c == hrd_pkg::CHAR_FF))
                        num_state = DIG_DONE;
                end
                DIG_READ:
                begin
                    if (!digit)
                        num_state = DIG_DONE;
                    else if (len_acc > (32'hFFFF_FFFF - d) / 10)
                        len_acc = '1;
                    else
                        len_acc = len_acc * 10 + d;
                end
                default: ;
            endcase
        end
        tail_chars = {tail_chars[hrd_pkg::TAIL_BITS-9:0], c};
        if (line_len != '1)
            line_len = line_len + 16'd1;
    endfunction

    // Close the current line; return 1 for a rejected status line
    function automatic logic finish_line();
        if (rx_phase == hrd_pkg::PH_HEADERS)
        begin
            if (line_len == 0)
            begin
                rx_phase   = hrd_pkg::PH_BODY;
                close_flag = 1'b1;
            end
            else if (prefix_hit(hrd_pkg::PAT_CLEN))
                body_len = len_acc;
            else if (prefix_hit(hrd_pkg::PAT_CONN))
                want_close = 1'b1;
            restart_line();
            return 1'b0;
        end
        want_close = 1'b0;
        close_flag = 1'b0;
        if (prefix_hit(hrd_pkg::PAT_OK_10) || prefix_hit(hrd_pkg::PAT_OK_11) ||
            (line_len >= hrd_pkg::TAIL_LEN &&
             (tail_chars == hrd_pkg::TAIL_OK_10 || tail_chars == hrd_pkg::TAIL_OK_11)))
        begin
            rx_phase = hrd_pkg::PH_HEADERS;
            restart_line();
        end
        else if (prefix_hit(hrd_pkg::PAT_V10) || prefix_hit(hrd_pkg::PAT_V11))
        begin
            err_reply = 1'b1;
            rx_phase  = hrd_pkg::PH_HEADERS;
            restart_line();
        end
        else
        begin
            restart_reply();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic take_char(input logic [7:0] b);
        if (b == hrd_pkg::CHAR_LF)
            return finish_line();
        if (b != hrd_pkg::CHAR_CR)
            add_char(b);
        return 1'b0;
    endfunction

    // Advance the model by one received byte and return the result it yields
    function automatic hrd_pkg::result_t parse_byte(input logic [7:0] b,
                                                    input logic idle);
        hrd_pkg::result_t r;
        logic             taken;
        logic             keep;
        r = '0;
        if (rx_phase == hrd_pkg::PH_BODY)
        begin
            taken = 1'b0;
            if (body_cnt < body_len)
            begin
                body_cnt     = body_cnt + 32'd1;
                taken        = 1'b1;
                r.body_valid = !err_reply;
            end
            // End of body: count reached or downstream went back to hunting
            if (idle || body_cnt >= body_len)
            begin
                keep         = close_flag;
                r.disconnect = want_close;
                restart_reply();
                close_flag   = keep;
                r.reply_done = 1'b1;
            end
            // A byte the body did not take starts the next status line
            if (!taken)
                r.bad_status = take_char(b);
        end
        else
            r.bad_status = take_char(b);
        if (r.body_valid)
            r.body_byte = b;
        r.close_expected = close_flag;
        r.phase          = rx_phase;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall bursts; a burst starts with a chance of 2 in a hundred
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (!no_idle_stretch && $urandom_range(99) < 2)
        begin
            stall_left   <= $urandom_range(0, 4);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin : result_check
        hrd_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (due_results.size() == 0)
            begin
                $error("result transfer with no prediction pending");
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("body_valid", 8'(want.body_valid), 8'(body_valid));
                check_field("body_byte", want.body_byte, body_byte);
                check_field("reply_done", 8'(want.reply_done), 8'(reply_done));
                check_field("disconnect", 8'(want.disconnect), 8'(disconnect));
                check_field("bad_status", 8'(want.bad_status), 8'(bad_status));
                check_field("close_expected", 8'(want.close_expected),
                            8'(close_expected));
                check_field("phase", 8'(want.phase), 8'(phase));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------------

    // Transfer one byte; idle the channel now and then before presenting it
    task automatic send_byte(input logic [7:0] b, input logic idle);
        if (!no_idle_stretch && $urandom_range(99) < 2)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_valid      <= 1'b1;
        data_byte       <= b;
        downstream_idle <= idle;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        due_results.push_back(parse_byte(b, idle));
        bytes_sent++;
    endtask

    // Send text, optionally flipping the case of letters at random
    task automatic send_text(input string s, input bit mixed);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (mixed && ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z") && $urandom_range(1))
                c = c ^ 8'h20;
            send_byte(c, 1'($urandom_range(1)));
        end
    endtask

    task automatic send_eol();
        if ($urandom_range(1))
            send_byte(hrd_pkg::CHAR_CR, 1'($urandom_range(1)));
        send_byte(hrd_pkg::CHAR_LF, 1'($urandom_range(1)));
    endtask

    task automatic send_junk(input int n);
        logic [7:0] c;
        repeat (n)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == hrd_pkg::CHAR_LF)
                c = 8'h00;
            send_byte(c, 1'($urandom_range(1)));
        end
    endtask

    // Hold the item side until every predicted result has been transferred
    task automatic wait_for_results();
        item_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_status_line();
        string s;
        int    k;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                if ($urandom_range(1))
                    s = "HTTP/1.0 200";
                else
                    s = "HTTP/1.0 200 OK";
            end
            2, 3:
            begin
                if ($urandom_range(1))
                    s = "HTTP/1.1 200 OK";
                else
                    s = "HTTP/1.1 200";
            end
            4:
            begin
                // Leading junk defeats the prefix; only the line tail matches
                send_junk($urandom_range(1, 3));
                s = $urandom_range(1) ? "HTTP/1.1 200 OK" : "HTTP/1.0 200 OK";
            end
            5, 6:
            begin
                if ($urandom_range(1))
                    s = "HTTP/1.1 404 Not Found";
                else
                    s = "HTTP/1.0 500";
            end
            7:
            begin
                // Corrupt one character of a good status line
                s = "HTTP/1.1 200 OK";
                k = $urandom_range(0, s.len() - 1);
                for (int i = 0; i < s.len(); i++)
                    send_byte((i == k) ? 8'($urandom_range(0, 255)) : 8'(s[i]),
                              1'($urandom_range(1)));
                s = "";
            end
            8: s = "http/1.1 200 OK";
            default:
            begin
                send_junk($urandom_range(0, 12));
                s = "";
            end
        endcase
        send_text(s, 1'b0);
        send_eol();
    endtask

    task automatic send_length_header();
        string digits;
        logic [7:0] ws;
        send_text("Content-Length: ", 1'b1);
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0:       ws = hrd_pkg::CHAR_SP;
                1:       ws = hrd_pkg::CHAR_TAB;
                2:       ws = hrd_pkg::CHAR_VT;
                default: ws = hrd_pkg::CHAR_FF;
            endcase
            send_byte(ws, 1'($urandom_range(1)));
        end
        case ($urandom_range(0, 11))
            0:       digits = "4294967295";
            1:       digits = "4294967296";
            2:       digits = "987654321098";
            3:       digits = "-7";
            4:       digits = "";
            default: digits = $sformatf("%0d", $urandom_range(0, 24));
        endcase
        send_text(digits, 1'b0);
        if ($urandom_range(99) < 15)
            send_text($urandom_range(1) ? " 9" : "x5", 1'b0);
    endtask

    task automatic send_header_line();
        case ($urandom_range(0, 6))
            0, 1, 2: send_length_header();
            3:       send_text("Connection: Close", 1'b1);
            4:       send_text("Connection: keep-alive", 1'b0);
            5:       send_text($urandom_range(1) ? "Content-Length:7" : "Content-Lengt: 7", 1'b1);
            default:
            begin
                send_text("X-Pad: ", 1'b0);
                send_junk($urandom_range(0, 16));
            end
        endcase
        if (rx_phase != hrd_pkg::PH_BODY)
            send_eol();
    endtask

    // One response: status line, headers, empty line, then body bytes until
    // the model leaves the body; force downstream idle after a cap
    task automatic send_reply();
        int cap;
        int n;
        send_status_line();
        repeat ($urandom_range(0, 4))
            send_header_line();
        send_eol();
        cap = $urandom_range(2, 40);
        n   = 0;
        while (rx_phase == hrd_pkg::PH_BODY)
        begin
            send_byte(8'($urandom_range(0, 255)), (n >= cap) || ($urandom_range(99) < 3));
            n++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // 200 reply with no length: the first byte after the headers ends the
    // body and opens a new status line, which holds only extreme bytes and
    // so is rejected
    task automatic test_minimal_reply();
        send_text("HTTP/1.1 200", 1'b0);
        send_byte(hrd_pkg::CHAR_LF, 1'b0);
        send_byte(hrd_pkg::CHAR_LF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(hrd_pkg::CHAR_LF, 1'b1);
    endtask

    // Non-200 HTTP/1.0 reply: CR LF ends the status line, a bare LF the empty line; empty body
    task automatic test_error_reply();
        send_text("HTTP/1.0 ", 1'b0);
        send_byte(hrd_pkg::CHAR_CR, 1'b0);
        send_byte(hrd_pkg::CHAR_LF, 1'b1);
        send_byte(hrd_pkg::CHAR_LF, 1'b0);
        send_byte(hrd_pkg::CHAR_CR, 1'b1);
    endtask

    // Mostly well-formed replies with random content, some noise lines;
    // drain once early and run a stretch with no idling on either side
    task automatic test_random_replies();
        int reply_no;
        reply_no = 0;
        while (bytes_sent < 800)
        begin
            no_idle_stretch = (bytes_sent >= 350 && bytes_sent < 600);
            if (reply_no == 4)
                wait_for_results();
            if ($urandom_range(99) < 10)
            begin
                send_junk($urandom_range(1, 10));
                send_byte(hrd_pkg::CHAR_LF, 1'($urandom_range(1)));
            end
            else
                send_reply();
            reply_no++;
        end
        no_idle_stretch = 1'b0;
    endtask

    // A long header line must not read as empty at its end
    task automatic test_long_header_line();
        send_text("HTTP/1.1 200", 1'b0);
        send_byte(hrd_pkg::CHAR_LF, 1'b0);
        repeat (200)
            send_byte("a", 1'($urandom_range(1)));
        send_byte(hrd_pkg::CHAR_LF, 1'b0);
        send_byte(hrd_pkg::CHAR_LF, 1'b0);
        send_byte(hrd_pkg::CHAR_LF, 1'b0);
    endtask

    initial
    begin
        restart_reply();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_minimal_reply();
        test_error_reply();
        test_random_replies();
        test_long_header_line();
        item_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
